>>> rtl/drtt_pkg.sv
// ----------------------------------------------------------------------------
// drtt_pkg: shared types and constants of the direction repeat and tap tracker
// Holds field widths, register indexes, reset values, sequencer state types
// and the control and status bundles between the top level and the touch unit.
// ----------------------------------------------------------------------------
package drtt_pkg;

   localparam int DIRECTIONS = 4;

   // Field widths
   localparam int STICK_W   = 16;
   localparam int TIME_W    = 24;
   localparam int RAW_W     = 12;
   localparam int POS_W     = 18;
   localparam int DELTA_W   = 19;
   localparam int TIMER_W   = 26;
   localparam int DZ_W      = 15;
   localparam int SCALE_W   = 19;
   localparam int SLOP_W    = 16;

   // Configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   localparam logic [CSR_IDX_W-1:0] CSR_STICK_DEADZONE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REPEAT_DELAY     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REPEAT_PERIOD    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_RECIPROCAL = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TAP_SLOP         = 3'd4;

   localparam logic [DZ_W-1:0]    RST_STICK_DEADZONE   = 15'd16384;
   localparam logic [TIME_W-1:0]  RST_REPEAT_DELAY     = 24'd400000;
   localparam logic [TIME_W-1:0]  RST_REPEAT_PERIOD    = 24'd100000;
   localparam logic [SCALE_W-1:0] RST_SCALE_RECIPROCAL = 19'd65536;
   localparam logic [SLOP_W-1:0]  RST_TAP_SLOP         = 16'd160;

   // Stick magnitude that counts as pad activity (0.3 of full scale).
   localparam logic signed [STICK_W:0] STICK_PAD_LIMIT = 17'sd9830;

   typedef enum logic {
      ST_IDLE,
      ST_WORK
   } drtt_state_type;

   typedef enum logic [2:0] {
      TP_IDLE,
      TP_MUL,
      TP_POS,
      TP_DIFF,
      TP_SQ,
      TP_CMP,
      TP_DONE
   } tch_phase_type;

   typedef struct packed {
      logic start;
      logic commit;
   } tch_ctrl_type;

   typedef struct packed {
      logic                      done;
      logic                      pressed;
      logic                      released;
      logic                      tap;
      logic [POS_W-1:0]          pos_x;
      logic [POS_W-1:0]          pos_y;
      logic signed [DELTA_W-1:0] dx;
      logic signed [DELTA_W-1:0] dy;
   } tch_stat_type;

endpackage

>>> rtl/drtt_lane.sv
// ----------------------------------------------------------------------------
// drtt_lane: auto-repeat lane for one direction
// Fires on activation, then after the repeat delay and every repeat period
// while the direction stays active. The timer saturates at its floor and is
// reloaded at most once per frame.
// ----------------------------------------------------------------------------
module drtt_lane (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           commit,
   input  logic                           active,
   input  logic [drtt_pkg::TIME_W-1:0]    elapsed,
   input  logic [drtt_pkg::TIME_W-1:0]    repeat_delay,
   input  logic [drtt_pkg::TIME_W-1:0]    repeat_period,
   output logic                           fire
);
   import drtt_pkg::*;

   localparam logic signed [TIMER_W:0] TIMER_FLOOR = -27'sd33554432;

   logic                      held_ff;
   logic                      held_in;
   logic signed [TIMER_W-1:0] timer_ff;
   logic signed [TIMER_W-1:0] timer_in;
   logic signed [TIMER_W:0]   t_sub;
   logic signed [TIMER_W:0]   t_sat;
   logic signed [TIMER_W:0]   t_rel;

   always_comb begin
      t_sub = {timer_ff[TIMER_W-1], timer_ff} - {3'b000, elapsed};
      t_sat = (t_sub < TIMER_FLOOR) ? TIMER_FLOOR : t_sub;
      t_rel = t_sat + {3'b000, repeat_period};
      held_in  = held_ff;
      timer_in = timer_ff;
      fire     = 1'b0;
      if (!active) begin
         held_in  = 1'b0;
         timer_in = '0;
      end else if (!held_ff) begin
         held_in  = 1'b1;
         timer_in = {2'b00, repeat_delay};
         fire     = 1'b1;
      end else if (t_sat <= 27'sd0) begin
         timer_in = t_rel[TIMER_W-1:0];
         fire     = 1'b1;
      end else begin
         timer_in = t_sat[TIMER_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff  <= 1'b0;
         timer_ff <= '0;
      end else if (commit) begin
         held_ff  <= held_in;
         timer_ff <= timer_in;
      end
   end

endmodule

>>> rtl/drtt_touch.sv
// ----------------------------------------------------------------------------
// drtt_touch: touch edge, position, delta and tap tracking unit
// Scales raw coordinates, forms deltas from the last and start positions and
// tests the squared distance against the squared slop over five steps:
// multiply, position, difference, square and compare. State is updated
// when the top level commits.
module drtt_touch (
   input  logic                          clock,
   input  logic                          reset,
   input  drtt_pkg::tch_ctrl_type        ctrl,
   input  logic                          present,
   input  logic [drtt_pkg::RAW_W-1:0]    raw_x,
   input  logic [drtt_pkg::RAW_W-1:0]    raw_y,
   input  logic [drtt_pkg::SCALE_W-1:0]  scale_reciprocal,
   input  logic [drtt_pkg::SLOP_W-1:0]   tap_slop,
   output drtt_pkg::tch_stat_type        stat
);
   import drtt_pkg::*;

   localparam int PROD_W = RAW_W + SCALE_W;
   localparam int SQ_W   = 2 * DELTA_W - 1;

   tch_phase_type phase_ff;
   tch_phase_type phase_in;

   // Tracked touch state
   logic             active_ff;
   logic             tap_ff;
   logic [POS_W-1:0] last_x_ff;
   logic [POS_W-1:0] last_y_ff;
   logic [POS_W-1:0] start_x_ff;
   logic [POS_W-1:0] start_y_ff;

   // Datapath steps
   logic [PROD_W-1:0]         prod_x_ff;
   logic [PROD_W-1:0]         prod_y_ff;
   logic [POS_W-1:0]          pos_x_ff;
   logic [POS_W-1:0]          pos_y_ff;
   logic signed [DELTA_W-1:0] mx_ff;
   logic signed [DELTA_W-1:0] my_ff;
   logic signed [DELTA_W-1:0] ddx_ff;
   logic signed [DELTA_W-1:0] ddy_ff;
   logic [SQ_W-1:0]           sq_x_ff;
   logic [SQ_W-1:0]           sq_y_ff;
   logic [2*SLOP_W-1:0]       slop_sq_ff;
   logic                      far_ff;

   logic [PROD_W-13:0]        shift_x;
   logic [PROD_W-13:0]        shift_y;
   logic signed [2*DELTA_W-1:0] sq_x;
   logic signed [2*DELTA_W-1:0] sq_y;
   logic [SQ_W:0]             dist_sq;

   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         TP_IDLE: if (ctrl.start) begin
            phase_in = TP_MUL;
         end
         TP_MUL:  phase_in = TP_POS;
         TP_POS:  phase_in = TP_DIFF;
         TP_DIFF: phase_in = TP_SQ;
         TP_SQ:   phase_in = TP_CMP;
         TP_CMP:  phase_in = TP_DONE;
         TP_DONE: if (ctrl.commit) begin
            phase_in = TP_IDLE;
         end
         default: phase_in = TP_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= TP_IDLE;
      end else begin
         phase_ff <= phase_in;
      end
   end

   always_comb begin
      shift_x = prod_x_ff[PROD_W-1:12];
      shift_y = prod_y_ff[PROD_W-1:12];
      sq_x    = mx_ff * mx_ff;
      sq_y    = my_ff * my_ff;
      dist_sq = {1'b0, sq_x_ff} + {1'b0, sq_y_ff};
   end

   always_ff @(posedge clock) begin
      case (phase_ff)
         TP_MUL: begin
            prod_x_ff <= PROD_W'(raw_x) * PROD_W'(scale_reciprocal);
            prod_y_ff <= PROD_W'(raw_y) * PROD_W'(scale_reciprocal);
         end
         TP_POS: begin
            // Position saturates at the largest Q.4 value.
            pos_x_ff <= shift_x[POS_W] ? '1 : shift_x[POS_W-1:0];
            pos_y_ff <= shift_y[POS_W] ? '1 : shift_y[POS_W-1:0];
         end
         TP_DIFF: begin
            mx_ff  <= {1'b0, pos_x_ff} - {1'b0, start_x_ff};
            my_ff  <= {1'b0, pos_y_ff} - {1'b0, start_y_ff};
            ddx_ff <= {1'b0, pos_x_ff} - {1'b0, last_x_ff};
            ddy_ff <= {1'b0, pos_y_ff} - {1'b0, last_y_ff};
         end
         TP_SQ: begin
            sq_x_ff    <= sq_x[SQ_W-1:0];
            sq_y_ff    <= sq_y[SQ_W-1:0];
            slop_sq_ff <= (2*SLOP_W)'(tap_slop) * (2*SLOP_W)'(tap_slop);
         end
         TP_CMP: begin
            far_ff <= dist_sq > (SQ_W+1)'(slop_sq_ff);
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      stat.done     = (phase_ff == TP_DONE);
      stat.pressed  = present && !active_ff;
      stat.released = !present && active_ff;
      stat.tap      = tap_ff;
      stat.pos_x    = last_x_ff;
      stat.pos_y    = last_y_ff;
      stat.dx       = '0;
      stat.dy       = '0;
      if (present) begin
         stat.pos_x = pos_x_ff;
         stat.pos_y = pos_y_ff;
         if (!active_ff) begin
            stat.tap = 1'b1;
         end else begin
            stat.tap = tap_ff && !far_ff;
            stat.dx  = ddx_ff;
            stat.dy  = ddy_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff  <= 1'b0;
         tap_ff     <= 1'b0;
         last_x_ff  <= '0;
         last_y_ff  <= '0;
         start_x_ff <= '0;
         start_y_ff <= '0;
      end else if (ctrl.commit) begin
         active_ff <= present;
         tap_ff    <= stat.tap;
         last_x_ff <= stat.pos_x;
         last_y_ff <= stat.pos_y;
         if (stat.pressed) begin
            start_x_ff <= pos_x_ff;
            start_y_ff <= pos_y_ff;
         end
      end
   end

endmodule

>>> rtl/direction_repeat_and_tap_tracker.sv
// ----------------------------------------------------------------------------
// direction_repeat_and_tap_tracker: pad auto-repeat and touch tap tracker
// A request is registered, runs the five-step touch multiply and
// distance-compare sequence and is then committed to the output register.
// A new request is taken only after the last one has been committed.
// A result waiting in the output register delays only the commit step.
// Reset clears all tracking state and loads the configuration defaults.
// ----------------------------------------------------------------------------
module direction_repeat_and_tap_tracker (
   input  logic                                   clock,
   input  logic                                   reset,

   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [drtt_pkg::DIRECTIONS-1:0]        req_dpad_held,
   input  logic                                   req_any_direction_held,
   input  logic                                   req_any_button_pressed,
   input  logic signed [drtt_pkg::STICK_W-1:0]    req_stick_x,
   input  logic signed [drtt_pkg::STICK_W-1:0]    req_stick_y,
   input  logic [drtt_pkg::TIME_W-1:0]            req_elapsed,
   input  logic                                   req_touch_present,
   input  logic [drtt_pkg::RAW_W-1:0]             req_touch_raw_x,
   input  logic [drtt_pkg::RAW_W-1:0]             req_touch_raw_y,

   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [drtt_pkg::DIRECTIONS-1:0]        rsp_navigate,
   output logic                                   rsp_touch_owns_cursor,
   output logic                                   rsp_touch_pressed,
   output logic                                   rsp_touch_released,
   output logic                                   rsp_still_a_tap,
   output logic [drtt_pkg::POS_W-1:0]             rsp_touch_x,
   output logic [drtt_pkg::POS_W-1:0]             rsp_touch_y,
   output logic signed [drtt_pkg::DELTA_W-1:0]    rsp_touch_dx,
   output logic signed [drtt_pkg::DELTA_W-1:0]    rsp_touch_dy,

   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [drtt_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [drtt_pkg::CSR_DATA_W-1:0]        csr_wdata
);
   import drtt_pkg::*;

   // ------------------------------------------------------------------------
   // Configuration registers. Writes are always taken; an index past the
   // last register is dropped.
   // ------------------------------------------------------------------------
   logic [DZ_W-1:0]    stick_deadzone_ff;
   logic [TIME_W-1:0]  repeat_delay_ff;
   logic [TIME_W-1:0]  repeat_period_ff;
   logic [SCALE_W-1:0] scale_reciprocal_ff;
   logic [SLOP_W-1:0]  tap_slop_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         stick_deadzone_ff   <= RST_STICK_DEADZONE;
         repeat_delay_ff     <= RST_REPEAT_DELAY;
         repeat_period_ff    <= RST_REPEAT_PERIOD;
         scale_reciprocal_ff <= RST_SCALE_RECIPROCAL;
         tap_slop_ff         <= RST_TAP_SLOP;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_STICK_DEADZONE:   stick_deadzone_ff   <= csr_wdata[DZ_W-1:0];
            CSR_REPEAT_DELAY:     repeat_delay_ff     <= csr_wdata[TIME_W-1:0];
            CSR_REPEAT_PERIOD:    repeat_period_ff    <= csr_wdata[TIME_W-1:0];
            CSR_SCALE_RECIPROCAL: scale_reciprocal_ff <= csr_wdata[SCALE_W-1:0];
            CSR_TAP_SLOP:         tap_slop_ff         <= csr_wdata[SLOP_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Request capture. The frame is held in these registers while the touch
   // unit runs its sequence; the lanes and the pad check read them at commit.
   // ------------------------------------------------------------------------
   logic [DIRECTIONS-1:0]     dpad_ff;
   logic                      any_dir_ff;
   logic                      any_btn_ff;
   logic signed [STICK_W-1:0] stick_x_ff;
   logic signed [STICK_W-1:0] stick_y_ff;
   logic [TIME_W-1:0]         elapsed_ff;
   logic                      present_ff;
   logic [RAW_W-1:0]          raw_x_ff;
   logic [RAW_W-1:0]          raw_y_ff;

   logic req_fire;
   assign req_fire = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (req_fire) begin
         dpad_ff    <= req_dpad_held;
         any_dir_ff <= req_any_direction_held;
         any_btn_ff <= req_any_button_pressed;
         stick_x_ff <= req_stick_x;
         stick_y_ff <= req_stick_y;
         elapsed_ff <= req_elapsed;
         present_ff <= req_touch_present;
         raw_x_ff   <= req_touch_raw_x;
         raw_y_ff   <= req_touch_raw_y;
      end
   end

   // ------------------------------------------------------------------------
   // Sequencer. A request is taken only while idle. The work state lasts
   // until the touch unit is done and the output register is free, and the
   // commit in that cycle updates all tracking state at once.
   // ------------------------------------------------------------------------
   drtt_state_type state_ff;
   drtt_state_type state_in;
   tch_ctrl_type   tch_ctrl;
   tch_stat_type   tch_stat;
   logic           out_free;
   logic           commit;

   assign out_free = !rsp_valid || rsp_ready;

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      commit    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               state_in = ST_WORK;
            end
         end
         ST_WORK: begin
            if (tch_stat.done && out_free) begin
               commit   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      tch_ctrl.start  = req_fire;
      tch_ctrl.commit = commit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ------------------------------------------------------------------------
   // Touch unit.
   // ------------------------------------------------------------------------
   drtt_touch u_touch (
      .clock            (clock),
      .reset            (reset),
      .ctrl             (tch_ctrl),
      .present          (present_ff),
      .raw_x            (raw_x_ff),
      .raw_y            (raw_y_ff),
      .scale_reciprocal (scale_reciprocal_ff),
      .tap_slop         (tap_slop_ff),
      .stat             (tch_stat)
   );

   // ------------------------------------------------------------------------
   // Direction lanes. Each direction is active from its pad bit or from the
   // stick lying past the deadzone on its side (left and down are the
   // negative sides). The four lanes run side by side.
   // ------------------------------------------------------------------------
   logic signed [STICK_W:0] sx_ext;
   logic signed [STICK_W:0] sy_ext;
   logic signed [STICK_W:0] dz_pos;
   logic signed [STICK_W:0] dz_neg;
   logic [DIRECTIONS-1:0]   dir_now;
   logic [DIRECTIONS-1:0]   lane_fire;

   always_comb begin
      sx_ext = {stick_x_ff[STICK_W-1], stick_x_ff};
      sy_ext = {stick_y_ff[STICK_W-1], stick_y_ff};
      dz_pos = {2'b00, stick_deadzone_ff};
      dz_neg = -dz_pos;
      dir_now[0] = dpad_ff[0] || (sx_ext < dz_neg);
      dir_now[1] = dpad_ff[1] || (sx_ext > dz_pos);
      dir_now[2] = dpad_ff[2] || (sy_ext > dz_pos);
      dir_now[3] = dpad_ff[3] || (sy_ext < dz_neg);
   end

   for (genvar i = 0; i < DIRECTIONS; i++) begin : g_lane
      drtt_lane u_lane (
         .clock         (clock),
         .reset         (reset),
         .commit        (commit),
         .active        (dir_now[i]),
         .elapsed       (elapsed_ff),
         .repeat_delay  (repeat_delay_ff),
         .repeat_period (repeat_period_ff),
         .fire          (lane_fire[i])
      );
   end

   // ------------------------------------------------------------------------
   // Cursor ownership. A touch press hands the cursor to touch; any pad
   // activity in the same frame, including the stick beyond the fixed pad
   // limit, takes it back and wins over the press.
   // ------------------------------------------------------------------------
   logic pad_activity;
   logic driven_ff;
   logic driven_in;

   always_comb begin
      pad_activity = any_btn_ff || any_dir_ff
                  || (sx_ext > STICK_PAD_LIMIT) || (sx_ext < -STICK_PAD_LIMIT)
                  || (sy_ext > STICK_PAD_LIMIT) || (sy_ext < -STICK_PAD_LIMIT);
      driven_in = driven_ff;
      if (tch_stat.pressed) begin
         driven_in = 1'b1;
      end
      if (pad_activity) begin
         driven_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         driven_ff <= 1'b0;
      end else if (commit) begin
         driven_ff <= driven_in;
      end
   end

   // ------------------------------------------------------------------------
   // Merge and output register. The lane fire bits are gathered into the
   // navigate vector and the response is loaded at commit.
   // ------------------------------------------------------------------------
   logic                      rsp_valid_ff;
   logic [DIRECTIONS-1:0]     rsp_navigate_ff;
   logic                      rsp_owns_ff;
   logic                      rsp_pressed_ff;
   logic                      rsp_released_ff;
   logic                      rsp_tap_ff;
   logic [POS_W-1:0]          rsp_x_ff;
   logic [POS_W-1:0]          rsp_y_ff;
   logic signed [DELTA_W-1:0] rsp_dx_ff;
   logic signed [DELTA_W-1:0] rsp_dy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_navigate_ff <= lane_fire;
         rsp_owns_ff     <= driven_in;
         rsp_pressed_ff  <= tch_stat.pressed;
         rsp_released_ff <= tch_stat.released;
         rsp_tap_ff      <= tch_stat.tap;
         rsp_x_ff        <= tch_stat.pos_x;
         rsp_y_ff        <= tch_stat.pos_y;
         rsp_dx_ff       <= tch_stat.dx;
         rsp_dy_ff       <= tch_stat.dy;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_navigate          = rsp_navigate_ff;
   assign rsp_touch_owns_cursor = rsp_owns_ff;
   assign rsp_touch_pressed     = rsp_pressed_ff;
   assign rsp_touch_released    = rsp_released_ff;
   assign rsp_still_a_tap       = rsp_tap_ff;
   assign rsp_touch_x           = rsp_x_ff;
   assign rsp_touch_y           = rsp_y_ff;
   assign rsp_touch_dx          = rsp_dx_ff;
   assign rsp_touch_dy          = rsp_dy_ff;

   // ------------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------------

   // A touch cannot begin and end in the same frame.
   a_edges_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_pressed_ff && rsp_released_ff))
      else $error("touch press and release reported together");

   // The frame of a press reports no movement and starts a fresh tap.
   a_press_no_delta: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_pressed_ff) |->
         (rsp_dx_ff == '0) && (rsp_dy_ff == '0) && rsp_tap_ff)
      else $error("touch press reported with movement or without tap");

   // A commit always presents a response on the following cycle.
   a_commit_shows: assert property (@(posedge clock) disable iff (reset)
      commit |=> rsp_valid_ff)
      else $error("committed frame did not reach the output register");

   // Commit waits for the touch sequence to finish.
   a_commit_done: assert property (@(posedge clock) disable iff (reset)
      commit |-> (state_ff == ST_WORK) && tch_stat.done)
      else $error("commit before the touch sequence finished");

endmodule

>>> dv/direction_repeat_and_tap_tracker_test.sv
// ----------------------------------------------------------------------------
// direction_repeat_and_tap_tracker_test: self-checking bench for the tracker
// Sends sampled frames and register writes, predicts every response with a
// behavioral model of the repeat timers and touch tracking kept in this file,
// and compares responses field by field, mostly under random back pressure.
// ----------------------------------------------------------------------------
module direction_repeat_and_tap_tracker_test;
   import drtt_pkg::*;

   // Pacing and limits of the run.
   localparam int     IDLE_PCT      = 14;
   localparam int     SETTLE_CYCLES = 12;
   localparam int     PRINT_CAP     = 40;
   localparam int     PHASE_FRAMES  = 235;
   localparam longint TIMEOUT_TICKS = 64'd3_200_000;

   // Arithmetic limits of the predictor.
   localparam int     SCALE_SHIFT    = 12;
   localparam longint POS_LIMIT      = (longint'(1) << POS_W) - 1;
   localparam longint TIMER_FLOOR    = -(longint'(1) << (TIMER_W - 1));
   localparam int     TIME_MAX       = (1 << TIME_W) - 1;
   localparam int     RAW_MAX        = (1 << RAW_W) - 1;
   localparam int     STICK_TOP      = (1 << (STICK_W - 1)) - 1;
   localparam int     CSR_IDX_LAST   = (1 << CSR_IDX_W) - 1;
   localparam int     ACTIVITY_LIMIT = STICK_PAD_LIMIT;

   // Values that follow from the reset configuration, used by the typed rows.
   localparam int DZ_RESET    = RST_STICK_DEADZONE;
   localparam int SLOP_RESET  = RST_TAP_SLOP;
   localparam int POS_PER_RAW = RST_SCALE_RECIPROCAL >> SCALE_SHIFT;
   localparam int SLOP_RAW    = SLOP_RESET / POS_PER_RAW;
   localparam int CORNER_POS  = RAW_MAX * POS_PER_RAW;

   typedef struct packed {
      logic [DIRECTIONS-1:0] dpad;
      logic                  any_dir;
      logic                  any_btn;
      logic [STICK_W-1:0]    stick_x;
      logic [STICK_W-1:0]    stick_y;
      logic [TIME_W-1:0]     elapsed;
      logic                  present;
      logic [RAW_W-1:0]      raw_x;
      logic [RAW_W-1:0]      raw_y;
   } frame_t;

   typedef struct packed {
      logic [DIRECTIONS-1:0] navigate;
      logic                  owns;
      logic                  pressed;
      logic                  released;
      logic                  tap;
      logic [POS_W-1:0]      x;
      logic [POS_W-1:0]      y;
      logic [DELTA_W-1:0]    dx;
      logic [DELTA_W-1:0]    dy;
   } result_t;

   // One row of the directed table: a frame, and where the answer is obvious
   // from the reset configuration, the response typed in by hand.
   typedef struct packed {
      frame_t  frame;
      bit      typed;
      result_t want;
   } row_t;

   logic                           clock;
   logic                           reset;
   logic                           req_valid;
   logic                           req_ready;
   logic [DIRECTIONS-1:0]          req_dpad_held;
   logic                           req_any_direction_held;
   logic                           req_any_button_pressed;
   logic signed [STICK_W-1:0]      req_stick_x;
   logic signed [STICK_W-1:0]      req_stick_y;
   logic [TIME_W-1:0]              req_elapsed;
   logic                           req_touch_present;
   logic [RAW_W-1:0]               req_touch_raw_x;
   logic [RAW_W-1:0]               req_touch_raw_y;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   logic [DIRECTIONS-1:0]          rsp_navigate;
   logic                           rsp_touch_owns_cursor;
   logic                           rsp_touch_pressed;
   logic                           rsp_touch_released;
   logic                           rsp_still_a_tap;
   logic [POS_W-1:0]               rsp_touch_x;
   logic [POS_W-1:0]               rsp_touch_y;
   logic signed [DELTA_W-1:0]      rsp_touch_dx;
   logic signed [DELTA_W-1:0]      rsp_touch_dy;
   logic                           csr_valid;
   logic                           csr_ready;
   logic [CSR_IDX_W-1:0]           csr_index;
   logic [CSR_DATA_W-1:0]          csr_wdata;

   // Configuration as the predictor sees it, starting from the reset values.
   int cfg_deadzone = RST_STICK_DEADZONE;
   int cfg_delay    = RST_REPEAT_DELAY;
   int cfg_period   = RST_REPEAT_PERIOD;
   int cfg_scale    = RST_SCALE_RECIPROCAL;
   int cfg_slop     = RST_TAP_SLOP;

   // Tracking state of the predictor; everything clears on reset.
   bit [DIRECTIONS-1:0] dir_held = '0;
   int                  rep_timer[DIRECTIONS] = '{default: 0};
   bit                  touch_on = 1'b0;
   bit                  cursor_touch = 1'b0;
   bit                  tap_ok = 1'b0;
   longint              last_x = 0;
   longint              last_y = 0;
   longint              start_x = 0;
   longint              start_y = 0;

   // State of the random frame source: pad buttons and a finger persist
   // over several frames so that holds, repeats and drags actually happen.
   logic [DIRECTIONS-1:0] held_pad = '0;
   bit                    finger_down = 1'b0;
   int                    finger_x = 0;
   int                    finger_y = 0;

   result_t expected_reports[$];
   row_t    directed_rows[$];
   int      failures = 0;
   bit      steady_flow = 1'b0;

   direction_repeat_and_tap_tracker dut (.*);

   // Free running clock with a period of 8 time units.
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Hard stop in case the block stops answering.
   initial begin
      #(TIMEOUT_TICKS);
      $display("status: fail");
      $finish;
   end

   // Scales one raw coordinate into Q.4 display units. The product is taken
   // wide, truncated by the shift and then clamped to the position range.
   function automatic longint scaled_position(input logic [RAW_W-1:0] raw);
      longint p;
      p = (longint'(raw) * cfg_scale) >>> SCALE_SHIFT;
      return (p > POS_LIMIT) ? POS_LIMIT : p;
   endfunction

   // Predicts the response to one accepted request and advances the state.
   // The touch update runs first, then pad activity may take the cursor
   // back, and last the four repeat timers are stepped.
   task automatic track_frame(input frame_t f, output result_t r);
      int                    sx, sy, dz;
      longint                dt, t, x, y, ddx, ddy, mx, my;
      logic [DIRECTIONS-1:0] now_dir, nav;
      logic                  pressed, released;
      sx = $signed(f.stick_x);
      sy = $signed(f.stick_y);
      dz = cfg_deadzone;
      dt = f.elapsed;
      now_dir[0] = f.dpad[0] || sx < -dz;
      now_dir[1] = f.dpad[1] || sx > dz;
      now_dir[2] = f.dpad[2] || sy > dz;
      now_dir[3] = f.dpad[3] || sy < -dz;
      pressed  = f.present && !touch_on;
      released = !f.present && touch_on;
      ddx = 0;
      ddy = 0;
      nav = '0;

      if (!f.present) begin
         touch_on = 1'b0;
      end else begin
         x = scaled_position(f.raw_x);
         y = scaled_position(f.raw_y);
         if (pressed) begin
            // A new touch takes the cursor and starts a fresh tap.
            cursor_touch = 1'b1;
            start_x = x;
            start_y = y;
            tap_ok = 1'b1;
         end else begin
            ddx = x - last_x;
            ddy = y - last_y;
            mx = x - start_x;
            my = y - start_y;
            // Squared distances avoid a square root and stay exact.
            if (mx * mx + my * my > longint'(cfg_slop) * cfg_slop) begin
               tap_ok = 1'b0;
            end
         end
         last_x = x;
         last_y = y;
         touch_on = 1'b1;
      end

      // Pad activity overrides a touch press in the same frame.
      if (f.any_btn || f.any_dir || sx > ACTIVITY_LIMIT || sx < -ACTIVITY_LIMIT ||
          sy > ACTIVITY_LIMIT || sy < -ACTIVITY_LIMIT) begin
         cursor_touch = 1'b0;
      end

      for (int i = 0; i < DIRECTIONS; i++) begin
         if (!now_dir[i]) begin
            dir_held[i] = 1'b0;
            rep_timer[i] = 0;
         end else if (!dir_held[i]) begin
            dir_held[i] = 1'b1;
            rep_timer[i] = cfg_delay;
            nav[i] = 1'b1;
         end else begin
            // Saturate before the single reload, so a long frame gives at
            // most one event per direction.
            t = longint'(rep_timer[i]) - dt;
            if (t < TIMER_FLOOR) begin
               t = TIMER_FLOOR;
            end
            if (t <= 0) begin
               t = t + cfg_period;
               nav[i] = 1'b1;
            end
            rep_timer[i] = int'(t);
         end
      end

      r.navigate = nav;
      r.owns     = cursor_touch;
      r.pressed  = pressed;
      r.released = released;
      r.tap      = tap_ok;
      r.x        = last_x[POS_W-1:0];
      r.y        = last_y[POS_W-1:0];
      r.dx       = ddx[DELTA_W-1:0];
      r.dy       = ddy[DELTA_W-1:0];
   endtask

   function automatic frame_t frame_of(input int dpad, input int any_dir, input int any_btn,
                                       input int sx, input int sy, input int elapsed,
                                       input int present, input int rx, input int ry);
      frame_t f;
      f.dpad    = dpad[DIRECTIONS-1:0];
      f.any_dir = any_dir[0];
      f.any_btn = any_btn[0];
      f.stick_x = sx[STICK_W-1:0];
      f.stick_y = sy[STICK_W-1:0];
      f.elapsed = elapsed[TIME_W-1:0];
      f.present = present[0];
      f.raw_x   = rx[RAW_W-1:0];
      f.raw_y   = ry[RAW_W-1:0];
      return f;
   endfunction

   function automatic result_t result_of(input int nav, input int owns, input int pressed,
                                         input int released, input int tap, input int x,
                                         input int y, input int dx, input int dy);
      result_t r;
      r.navigate = nav[DIRECTIONS-1:0];
      r.owns     = owns[0];
      r.pressed  = pressed[0];
      r.released = released[0];
      r.tap      = tap[0];
      r.x        = x[POS_W-1:0];
      r.y        = y[POS_W-1:0];
      r.dx       = dx[DELTA_W-1:0];
      r.dy       = dy[DELTA_W-1:0];
      return r;
   endfunction

   task automatic add_row(input frame_t f, input bit typed, input result_t want);
      row_t row;
      row.frame = f;
      row.typed = typed;
      row.want  = want;
      directed_rows.push_back(row);
   endtask

   // Stick positions: mostly small so the touch cursor survives, some full
   // range, and some right at the deadzone edge on either side.
   function automatic int stick_value();
      int pick, v;
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
         v = int'($urandom_range(0, 2000)) - 1000;
      end else if (pick < 80) begin
         v = $signed(16'($urandom));
      end else begin
         v = cfg_deadzone + int'($urandom_range(0, 2)) - 1;
         if ($urandom_range(0, 1) == 1) begin
            v = -v;
         end
         if (v > STICK_TOP) begin
            v = STICK_TOP;
         end
         if (v < -STICK_TOP - 1) begin
            v = -STICK_TOP - 1;
         end
      end
      return v;
   endfunction

   // Finger motion: mostly jitter around the tap slop, some drags and jumps.
   function automatic int nudge(input int v);
      int pick, n;
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
         n = v + int'($urandom_range(0, 6)) - 3;
      end else if (pick < 95) begin
         n = v + int'($urandom_range(0, 80)) - 40;
      end else begin
         n = $urandom_range(0, RAW_MAX);
      end
      if (n < 0) begin
         n = 0;
      end
      if (n > RAW_MAX) begin
         n = RAW_MAX;
      end
      return n;
   endfunction

   task automatic random_frame(output frame_t f);
      int span, pick;
      if ($urandom_range(0, 99) < 15) begin
         held_pad = $urandom;
      end
      f.dpad    = held_pad;
      f.any_dir = ($urandom_range(0, 99) < 10);
      f.any_btn = ($urandom_range(0, 99) < 10);
      f.stick_x = 16'(stick_value());
      f.stick_y = 16'(stick_value());

      // Elapsed time scaled to the current timing so repeats come often,
      // with zero, full scale and fully random values mixed in.
      span = ((cfg_delay > cfg_period) ? cfg_delay : cfg_period) / 2 + 1;
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         f.elapsed = '0;
      end else if (pick < 16) begin
         f.elapsed = '1;
      end else if (pick < 24) begin
         f.elapsed = TIME_W'($urandom);
      end else begin
         f.elapsed = TIME_W'($urandom_range(0, span));
      end

      // A finger stays down for a run of frames: press, drag, release.
      if (finger_down) begin
         if ($urandom_range(0, 99) < 15) begin
            finger_down = 1'b0;
         end else begin
            finger_x = nudge(finger_x);
            finger_y = nudge(finger_y);
         end
      end else if ($urandom_range(0, 99) < 20) begin
         finger_down = 1'b1;
         finger_x = $urandom_range(0, RAW_MAX);
         finger_y = $urandom_range(0, RAW_MAX);
      end
      f.present = finger_down;
      f.raw_x   = finger_down ? RAW_W'(finger_x) : RAW_W'($urandom);
      f.raw_y   = finger_down ? RAW_W'(finger_y) : RAW_W'($urandom);
   endtask

   task automatic report_mismatch(input string what, input longint got, input longint want);
      failures++;
      if (failures <= PRINT_CAP) begin
         $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
      end
   endtask

   // Sends one request. An optional idle gap comes first; valid then stays
   // high with a steady payload until the block takes the request.
   task automatic send_frame(input frame_t f, input bit typed, input result_t want);
      result_t predicted;
      while (!steady_flow && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid              <= 1'b1;
      req_dpad_held          <= f.dpad;
      req_any_direction_held <= f.any_dir;
      req_any_button_pressed <= f.any_btn;
      req_stick_x            <= f.stick_x;
      req_stick_y            <= f.stick_y;
      req_elapsed            <= f.elapsed;
      req_touch_present      <= f.present;
      req_touch_raw_x        <= f.raw_x;
      req_touch_raw_y        <= f.raw_y;
      do @(posedge clock); while (!req_ready);
      // The predictor always runs so its state stays in step; a typed row
      // checks against the hand-written answer instead.
      track_frame(f, predicted);
      expected_reports.push_back(typed ? want : predicted);
   endtask

   // Waits until every outstanding request has been answered, then lets the
   // pipeline settle so that the block is idle.
   task automatic drain();
      req_valid <= 1'b0;
      while (expected_reports.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One register write. Valid is left high so back-to-back writes need no
   // second assignment in the same step; the caller lowers it.
   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_STICK_DEADZONE:   cfg_deadzone = data[DZ_W-1:0];
         CSR_REPEAT_DELAY:     cfg_delay    = data[TIME_W-1:0];
         CSR_REPEAT_PERIOD:    cfg_period   = data[TIME_W-1:0];
         CSR_SCALE_RECIPROCAL: cfg_scale    = data[SCALE_W-1:0];
         CSR_TAP_SLOP:         cfg_slop     = data[SLOP_W-1:0];
         default: ;
      endcase
   endtask

   // Reprograms every register while the block is idle, adds one write to an
   // unused index that must change nothing, then runs a stretch of frames.
   task automatic run_phase(input int dz, input int delay, input int period,
                            input int scale, input int slop, input bit steady);
      frame_t f;
      drain();
      steady_flow = steady;
      write_register(CSR_STICK_DEADZONE, dz);
      write_register(CSR_REPEAT_DELAY, delay);
      write_register(CSR_REPEAT_PERIOD, period);
      write_register(CSR_SCALE_RECIPROCAL, scale);
      write_register(CSR_TAP_SLOP, slop);
      write_register(CSR_IDX_W'($urandom_range(CSR_TAP_SLOP + 1, CSR_IDX_LAST)), $urandom);
      csr_valid <= 1'b0;
      repeat (PHASE_FRAMES) begin
         random_frame(f);
         send_frame(f, 1'b0, '0);
      end
   endtask

   task automatic check_report();
      result_t want;
      if (expected_reports.size() == 0) begin
         report_mismatch("response with no request outstanding", rsp_navigate, 0);
      end else begin
         want = expected_reports.pop_front();
         if (rsp_navigate !== want.navigate)
            report_mismatch("navigate", rsp_navigate, want.navigate);
         if (rsp_touch_owns_cursor !== want.owns)
            report_mismatch("touch_owns_cursor", rsp_touch_owns_cursor, want.owns);
         if (rsp_touch_pressed !== want.pressed)
            report_mismatch("touch_pressed", rsp_touch_pressed, want.pressed);
         if (rsp_touch_released !== want.released)
            report_mismatch("touch_released", rsp_touch_released, want.released);
         if (rsp_still_a_tap !== want.tap)
            report_mismatch("still_a_tap", rsp_still_a_tap, want.tap);
         if (rsp_touch_x !== want.x)
            report_mismatch("touch_x", rsp_touch_x, want.x);
         if (rsp_touch_y !== want.y)
            report_mismatch("touch_y", rsp_touch_y, want.y);
         if (rsp_touch_dx !== want.dx)
            report_mismatch("touch_dx", rsp_touch_dx[DELTA_W-1:0], want.dx);
         if (rsp_touch_dy !== want.dy)
            report_mismatch("touch_dy", rsp_touch_dy[DELTA_W-1:0], want.dy);
      end
   endtask

   // Response side: check whatever is handed over at this edge, using the
   // ready value that was in effect, then pick ready for the next cycle.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         check_report();
      end
      rsp_ready <= steady_flow || ($urandom_range(0, 99) >= IDLE_PCT);
   end

   initial begin
      req_valid              <= 1'b0;
      req_dpad_held          <= '0;
      req_any_direction_held <= 1'b0;
      req_any_button_pressed <= 1'b0;
      req_stick_x            <= '0;
      req_stick_y            <= '0;
      req_elapsed            <= '0;
      req_touch_present      <= 1'b0;
      req_touch_raw_x        <= '0;
      req_touch_raw_y        <= '0;
      csr_valid              <= 1'b0;
      csr_index              <= '0;
      csr_wdata              <= '0;
      reset                  <= 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed part, all under the reset configuration.
      // A quiet frame right after reset answers with all zeros.
      add_row(frame_of(0, 0, 0, 0, 0, 0, 0, 0, 0), 1, result_of(0, 0, 0, 0, 0, 0, 0, 0, 0));
      // All four pad directions fire at once on their first frame.
      add_row(frame_of(4'hF, 0, 0, 0, 0, 0, 0, 0, 0), 1,
              result_of(4'hF, 0, 0, 0, 0, 0, 0, 0, 0));
      // Elapsed time equal to the delay brings the timers to zero: repeat.
      add_row(frame_of(4'hF, 0, 0, 0, 0, RST_REPEAT_DELAY, 0, 0, 0), 1,
              result_of(4'hF, 0, 0, 0, 0, 0, 0, 0, 0));
      // Full-scale frames drive the timers down until they saturate.
      add_row(frame_of(4'hF, 0, 0, 0, 0, TIME_MAX, 0, 0, 0), 0, '0);
      add_row(frame_of(4'hF, 0, 0, 0, 0, TIME_MAX, 0, 0, 0), 0, '0);
      add_row(frame_of(4'hF, 0, 0, 0, 0, TIME_MAX, 0, 0, 0), 0, '0);
      // Stick at its extremes keeps left and up, drops right and down.
      add_row(frame_of(0, 0, 0, -STICK_TOP - 1, STICK_TOP, 0, 0, 0, 0), 0, '0);
      // The opposite corner presses right and down afresh.
      add_row(frame_of(0, 0, 0, STICK_TOP, -STICK_TOP - 1, 0, 0, 0, 0), 1,
              result_of(4'hA, 0, 0, 0, 0, 0, 0, 0, 0));
      // Exactly on the deadzone counts as nothing.
      add_row(frame_of(0, 0, 0, DZ_RESET, -DZ_RESET, 0, 0, 0, 0), 1,
              result_of(0, 0, 0, 0, 0, 0, 0, 0, 0));
      // One step past it on the other sides presses left and up.
      add_row(frame_of(0, 0, 0, -DZ_RESET - 1, DZ_RESET + 1, 0, 0, 0, 0), 1,
              result_of(4'h5, 0, 0, 0, 0, 0, 0, 0, 0));
      // Touch press in the far corner takes the cursor and starts a tap.
      add_row(frame_of(0, 0, 0, 0, 0, 0, 1, RAW_MAX, RAW_MAX), 1,
              result_of(0, 1, 1, 0, 1, CORNER_POS, CORNER_POS, 0, 0));
      // Moving exactly the slop keeps the tap alive.
      add_row(frame_of(0, 0, 0, 0, 0, 0, 1, RAW_MAX - SLOP_RAW, RAW_MAX), 1,
              result_of(0, 1, 0, 0, 1, CORNER_POS - SLOP_RESET, CORNER_POS, -SLOP_RESET, 0));
      // One raw step further ends the tap.
      add_row(frame_of(0, 0, 0, 0, 0, 0, 1, RAW_MAX - SLOP_RAW - 1, RAW_MAX), 0, '0);
      // Largest negative and positive deltas.
      add_row(frame_of(0, 0, 0, 0, 0, 0, 1, 0, 0), 0, '0);
      add_row(frame_of(0, 0, 0, 0, 0, 0, 1, RAW_MAX, RAW_MAX), 0, '0);
      // A button press while touching hands the cursor back to the pad.
      add_row(frame_of(0, 0, 1, 0, 0, 0, 1, RAW_MAX, RAW_MAX), 0, '0);
      // Release holds the last position; raw values are ignored.
      add_row(frame_of(0, 0, 0, 0, 0, 0, 0, 12'hAAA, 12'h555), 0, '0);
      add_row(frame_of(0, 0, 0, 0, 0, 0, 0, 12'h555, 12'hAAA), 0, '0);
      // Stick just past the activity limit beats a press in the same frame.
      add_row(frame_of(0, 0, 0, ACTIVITY_LIMIT + 1, 0, 0, 1, 100, 200), 0, '0);
      add_row(frame_of(0, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0);
      // Exactly on the activity limit is not pad activity.
      add_row(frame_of(0, 0, 0, ACTIVITY_LIMIT, -ACTIVITY_LIMIT, 0, 1, 12'h555, 12'hAAA),
              0, '0);
      // Stick just past the limit downward while the finger stays down.
      add_row(frame_of(0, 0, 0, 0, -ACTIVITY_LIMIT - 1, 0, 1, 12'h555, 12'hAAA), 0, '0);
      // The any-direction flag alone also counts as pad activity.
      add_row(frame_of(0, 1, 0, 0, 0, 0, 1, 12'h555, 12'hAAA), 0, '0);
      add_row(frame_of(0, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0);
      // Held pad buttons fire but do not take the cursor from a new touch.
      add_row(frame_of(4'h3, 0, 0, 0, 0, 0, 1, RAW_MAX, 0), 0, '0);
      foreach (directed_rows[i]) begin
         send_frame(directed_rows[i].frame, directed_rows[i].typed, directed_rows[i].want);
      end

      // Random part, one configuration per phase: the reset values, the low
      // and high extremes (the latter with no idling on either side), zero
      // delay, period and scale, a saturating scale, then random settings.
      run_phase(RST_STICK_DEADZONE, RST_REPEAT_DELAY, RST_REPEAT_PERIOD,
                RST_SCALE_RECIPROCAL, RST_TAP_SLOP, 1'b0);
      run_phase(0, 1, 1, 4096, 0, 1'b0);
      run_phase(STICK_TOP, TIME_MAX, TIME_MAX, 262144, 16'hFFFF, 1'b1);
      run_phase($urandom_range(0, STICK_TOP), 0, 0, 0, $urandom_range(0, 16'hFFFF), 1'b0);
      run_phase(9000, 3000, 1000, (1 << SCALE_W) - 1, 40, 1'b0);
      repeat (3) begin
         run_phase($urandom_range(0, STICK_TOP), $urandom_range(1, TIME_MAX),
                   $urandom_range(1, TIME_MAX), $urandom_range(4096, 262144),
                   $urandom_range(0, 16'hFFFF), 1'b0);
      end

      drain();
      if (failures == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
